FILE: hdl/xalu_pkg.sv
// Shared types, constants and helpers for the x86 ALU / register file block.
// No dependencies; imported by the execute unit, the top level and the bench.
`default_nettype none

package xalu_pkg;

	localparam int NUM_REGS = 15;
	localparam int REG_AW   = $clog2(NUM_REGS);
	localparam int IDX_W    = 4;
	localparam int DATA_W   = 16;

	localparam logic [IDX_W-1:0] FLAGS_IDX = 4'd14;

	localparam int FLAG_S_BIT = 7;
	localparam int FLAG_Z_BIT = 6;
	localparam int FLAG_P_BIT = 2;

	localparam logic [2:0] OP_NONE = 3'd0;
	localparam logic [2:0] OP_MOV  = 3'd1;
	localparam logic [2:0] OP_ADD  = 3'd2;
	localparam logic [2:0] OP_SUB  = 3'd3;
	localparam logic [2:0] OP_CMP  = 3'd4;

	typedef struct packed {
		logic [2:0]       op;
		logic [IDX_W-1:0] dest_index;
		logic             dest_high_half;
		logic             word_size;
		logic             source_is_immediate;
		logic [IDX_W-1:0] source_index;
		logic             source_high_half;
		logic [15:0]      immediate;
	} cmd_t;

	typedef struct packed {
		logic [15:0] old_value;
		logic [15:0] new_value;
		logic [15:0] flags_word;
	} rsp_t;

	// writeback from the execute unit
	typedef struct packed {
		logic              reg_we;
		logic [DATA_W-1:0] reg_data;
		logic [DATA_W-1:0] flags;
	} wb_t;

	// true when the index names an entry held in the RAM (not flags, not out of range)
	function automatic logic in_ram(input logic [IDX_W-1:0] idx);
		in_ram = (32'(idx) < NUM_REGS) && (idx != FLAGS_IDX);
	endfunction

endpackage

`default_nettype wire

FILE: hdl/xalu_ram.sv
// Generic RAM: one write port, two registered read ports.
// No dependencies.
`default_nettype none

module xalu_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	output      logic [WIDTH-1:0]         rdata_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output      logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

`default_nettype wire

FILE: hdl/xalu_exec.sv
// Execute unit: operand select, add/sub, byte merge and S/Z/P flag update.
// Depends on xalu_pkg.
`default_nettype none

module xalu_exec
	import xalu_pkg::*;
(
	input  wire cmd_t              cmd,
	input  wire logic [DATA_W-1:0] dreg,
	input  wire logic [DATA_W-1:0] sreg,
	input  wire logic [DATA_W-1:0] flags,
	output      rsp_t              rsp,
	output      wb_t               wb
);

	logic [DATA_W-1:0] dst, src, sum, diff, res, merged, base, fnew;
	logic              wr, fl;

	always_comb begin
		dst = cmd.word_size ? dreg
			: {8'h00, (cmd.dest_high_half ? dreg[15:8] : dreg[7:0])};
		if (cmd.source_is_immediate) begin
			src = cmd.word_size ? cmd.immediate : {8'h00, cmd.immediate[7:0]};
		end else begin
			src = cmd.word_size ? sreg
				: {8'h00, (cmd.source_high_half ? sreg[15:8] : sreg[7:0])};
		end
		sum  = dst + src;
		diff = dst - src;

		wr = 1'b0;
		fl = 1'b0;
		unique case (cmd.op) inside
			OP_MOV: begin
				res = src;
				wr  = 1'b1;
			end
			OP_ADD: begin
				res = sum;
				wr  = 1'b1;
				fl  = 1'b1;
			end
			OP_SUB: begin
				res = diff;
				wr  = 1'b1;
				fl  = 1'b1;
			end
			OP_CMP: begin
				res = diff;
				fl  = 1'b1;
			end
			default: begin
				res = dst;
			end
		endcase
		if (!cmd.word_size) begin
			res = {8'h00, res[7:0]};
		end

		// byte write touches only the selected half
		if (cmd.word_size) begin
			merged = res;
		end else if (cmd.dest_high_half) begin
			merged = {res[7:0], dreg[7:0]};
		end else begin
			merged = {dreg[15:8], res[7:0]};
		end

		// flags as destination: the write lands first, S/Z/P on top of it
		base = (wr && cmd.dest_index == FLAGS_IDX) ? merged : flags;
		fnew = base;
		if (fl) begin
			fnew[FLAG_S_BIT] = cmd.word_size ? res[15] : res[7];
			fnew[FLAG_Z_BIT] = (res == '0);
			fnew[FLAG_P_BIT] = ~^res[7:0];
		end

		wb.reg_we   = wr && in_ram(cmd.dest_index);
		wb.reg_data = merged;
		wb.flags    = fnew;

		rsp.old_value  = dst;
		rsp.new_value  = wr ? res : dst;
		rsp.flags_word = fnew;
	end

endmodule

`default_nettype wire

FILE: hdl/x86_alu_regfile_mov_add_sub_cmp.sv
// An accepted item is read from the RAM into stage 1, then executed into the output register.
// Throughput: one item per cycle unless the output is stalled with both stage 1 and it full.
// A write is forwarded to the item read in the same cycle, so dependent items run back to back.
// Reset (arst_n low, asynchronous): pipeline empty, flags zero, every RAM entry invalid.
// An invalid entry reads as zero, so the register file starts all zero with no clearing pass.
`default_nettype none

module x86_alu_regfile_mov_add_sub_cmp
	import xalu_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_valid,
	output      logic cmd_stall,
	input  wire cmd_t cmd,
	output      logic rsp_valid,
	input  wire logic rsp_stall,
	output      rsp_t rsp
);

	// --- handshake -----------------------------------------------------------
	logic s1_vld_q, rsp_vld_q;
	logic s1_adv, cmd_acc;

	// s1 moves on whenever the output register is free or being drained
	assign s1_adv    = s1_vld_q && (!rsp_vld_q || !rsp_stall);
	assign cmd_stall = s1_vld_q && rsp_vld_q && rsp_stall;
	assign cmd_acc   = cmd_valid && !cmd_stall;

	// --- register file storage ------------------------------------------------
	// Entry FLAGS_IDX lives in flags_q; the RAM slot at that index stays unused.
	logic [NUM_REGS-1:0] vld_q;        // entry written since reset
	logic [DATA_W-1:0]   flags_q;
	logic [DATA_W-1:0]   rd_dst, rd_src;
	logic                ram_we;
	wb_t                 wb;

	// stage 1 item and the valid bits sampled with its read
	cmd_t cmd_s1;
	logic dst_ok_s1, src_ok_s1;

	xalu_ram #(
		.WIDTH (DATA_W),
		.DEPTH (NUM_REGS)
	) u_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (cmd_s1.dest_index[REG_AW-1:0]),
		.wdata   (wb.reg_data),
		.re      (cmd_acc),
		.raddr_a (cmd.dest_index[REG_AW-1:0]),
		.rdata_a (rd_dst),
		.raddr_b (cmd.source_index[REG_AW-1:0]),
		.rdata_b (rd_src)
	);

	// --- stage 1: read data back, operands resolved -------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q <= 1'b0;
		end else if (cmd_acc) begin
			s1_vld_q <= 1'b1;
		end else if (s1_adv) begin
			s1_vld_q <= 1'b0;
		end
	end

	// valid bit sampled with the read; a write on the same edge is caught by forwarding
	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			cmd_s1    <= cmd;
			dst_ok_s1 <= in_ram(cmd.dest_index) && vld_q[cmd.dest_index[REG_AW-1:0]];
			src_ok_s1 <= in_ram(cmd.source_index) && vld_q[cmd.source_index[REG_AW-1:0]];
		end
	end

	// last RAM write, held until the next one; it is always the current value of its entry
	logic              lw_vld_q;
	logic [IDX_W-1:0]  lw_addr_q;
	logic [DATA_W-1:0] lw_data_q;

	logic [DATA_W-1:0] dreg, sreg;

	always_comb begin
		if (cmd_s1.dest_index == FLAGS_IDX) begin
			dreg = flags_q;
		end else if (lw_vld_q && lw_addr_q == cmd_s1.dest_index) begin
			dreg = lw_data_q;
		end else if (dst_ok_s1) begin
			dreg = rd_dst;
		end else begin
			dreg = '0;      // never written, or out of range
		end

		if (cmd_s1.source_index == FLAGS_IDX) begin
			sreg = flags_q;
		end else if (lw_vld_q && lw_addr_q == cmd_s1.source_index) begin
			sreg = lw_data_q;
		end else if (src_ok_s1) begin
			sreg = rd_src;
		end else begin
			sreg = '0;
		end
	end

	rsp_t rsp_d;

	xalu_exec u_exec (
		.cmd   (cmd_s1),
		.dreg  (dreg),
		.sreg  (sreg),
		.flags (flags_q),
		.rsp   (rsp_d),
		.wb    (wb)
	);

	// --- writeback, retiring with the item ------------------------------------
	assign ram_we = s1_adv && wb.reg_we;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			flags_q  <= '0;
			lw_vld_q <= 1'b0;
		end else if (s1_adv) begin
			flags_q <= wb.flags;
			if (wb.reg_we) begin
				vld_q[cmd_s1.dest_index[REG_AW-1:0]] <= 1'b1;
				lw_vld_q                             <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ram_we) begin
			lw_addr_q <= cmd_s1.dest_index;
			lw_data_q <= wb.reg_data;
		end
	end

	// --- output register ------------------------------------------------------
	rsp_t rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (s1_adv) begin
			rsp_vld_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_vld_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	// the flags entry is never written through the RAM
	a_no_flags_ram_write: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> cmd_s1.dest_index != FLAGS_IDX)
		else $error("RAM write to flags index");

	// a RAM write is captured for forwarding on the next cycle
	a_fwd_capture: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> (lw_vld_q && lw_addr_q == $past(cmd_s1.dest_index)
			&& lw_data_q == $past(wb.reg_data)))
		else $error("forwarding register missed a write");

	// a full pipeline behind a stalled output takes no new item
	a_full_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_vld_q && rsp_vld_q && rsp_stall) |-> !cmd_acc)
		else $error("item accepted while pipeline full");

	// compare never writes a register
	a_cmp_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_vld_q && cmd_s1.op == OP_CMP) |-> !ram_we)
		else $error("cmp wrote the register file");
`endif

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Self-checking bench for the x86 mov/add/sub/cmp execute stage and its register file.
// Depends on xalu_pkg (cmd_t, rsp_t, op codes, flag bits) and the block's top level only.
`timescale 1ns / 100ps

module tb;
	import xalu_pkg::*;

	// codes the package leaves unnamed: reserved ops, register indices and the index past the file
	localparam logic [2:0]       OP_RSVD5 = 3'd5;
	localparam logic [2:0]       OP_RSVD6 = 3'd6;
	localparam logic [2:0]       OP_RSVD7 = 3'd7;
	localparam logic [IDX_W-1:0] REG_NIL  = 4'd0;  // ordinary storage entry
	localparam logic [IDX_W-1:0] REG_A    = 4'd1;
	localparam logic [IDX_W-1:0] REG_B    = 4'd2;
	localparam logic [IDX_W-1:0] REG_C    = 4'd3;
	localparam logic [IDX_W-1:0] IDX_OOR  = 4'd15; // beyond NUM_REGS: reads zero, writes dropped

	localparam int HOLD_CYC    = 48;   // long receiver hold-off
	localparam int TAIL_CYC    = 6;    // tail after the last drain; catches stray results
	localparam int WDOG_LIMIT  = 1000; // cycles with no item moving on either side
	localparam int N_CHUNKS    = 8;
	localparam int CHUNK_ITEMS = 100;

	typedef struct {
		cmd_t c;
		bit   chk;  // expected result typed in below rather than predicted
		rsp_t e;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	cmd_t cmd = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	// shadow of the register file, entry FLAGS_IDX holding the flags word
	logic [15:0] gpr_shadow [16];
	rsp_t        pending_rsp [$];

	// knobs shared between the stimulus and the result sink
	bit tx_idle_on = 1'b1;
	bit rx_idle_on = 1'b1;
	bit rx_hold_req = 1'b0;

	int err_cnt = 0;
	int n_items = 0;
	int n_results = 0;
	int n_holds = 0;
	int n_drains = 0;
	int op_cnt [8];
	int idle_cyc = 0;

	x86_alu_regfile_mov_add_sub_cmp dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Predictor: register file access and one instruction's execution
	// ---------------------------------------------------------------

	function automatic logic [15:0] gpr_rd(input logic [IDX_W-1:0] idx);
		if (int'(idx) >= NUM_REGS)
			return 16'h0000;
		return gpr_shadow[idx];
	endfunction

	function automatic void gpr_wr(input logic [IDX_W-1:0] idx, input logic [15:0] v);
		if (int'(idx) < NUM_REGS)
			gpr_shadow[idx] = v;
	endfunction

	// operand read at size; half select only matters for byte access
	function automatic logic [15:0] part_rd(input logic [IDX_W-1:0] idx, input logic hi,
			input logic wd);
		logic [15:0] v;
		v = gpr_rd(idx);
		if (wd)
			return v;
		return hi ? {8'h00, v[15:8]} : {8'h00, v[7:0]};
	endfunction

	// a byte write leaves the other half alone
	function automatic void part_wr(input logic [IDX_W-1:0] idx, input logic hi,
			input logic wd, input logic [15:0] val);
		logic [15:0] v;
		v = gpr_rd(idx);
		if (wd)
			v = val;
		else if (hi)
			v[15:8] = val[7:0];
		else
			v[7:0] = val[7:0];
		gpr_wr(idx, v);
	endfunction

	function automatic rsp_t exec_cmd(input cmd_t c);
		logic [15:0] msk, top, dst, src, res, f;
		rsp_t r;
		msk = c.word_size ? 16'hFFFF : 16'h00FF;
		top = c.word_size ? 16'h8000 : 16'h0080;
		dst = part_rd(c.dest_index, c.dest_high_half, c.word_size);
		src = c.source_is_immediate ? (c.immediate & msk)
			: part_rd(c.source_index, c.source_high_half, c.word_size);
		res = dst;
		r.old_value = dst;
		r.new_value = dst;
		case (c.op) inside
			OP_MOV: res = src;
			OP_ADD: res = (dst + src) & msk;
			OP_SUB, OP_CMP: res = (dst - src) & msk;
			default: ;
		endcase
		// cmp leaves the destination alone; mov leaves the flags alone
		if (c.op == OP_MOV || c.op == OP_ADD || c.op == OP_SUB) begin
			part_wr(c.dest_index, c.dest_high_half, c.word_size, res);
			r.new_value = res;
		end
		// flags go on top of the written result when the flags word is the destination
		if (c.op == OP_ADD || c.op == OP_SUB || c.op == OP_CMP) begin
			f = gpr_rd(FLAGS_IDX);
			f[FLAG_S_BIT] = |(res & top);
			f[FLAG_Z_BIT] = (res == 16'h0000);
			f[FLAG_P_BIT] = ~^res[7:0];
			gpr_wr(FLAGS_IDX, f);
		end
		r.flags_word = gpr_rd(FLAGS_IDX);
		op_cnt[c.op]++;
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------

	function automatic dir_row_t row(input logic [2:0] op, input logic [IDX_W-1:0] di,
			input logic dh, input logic wd, input logic simm, input logic [IDX_W-1:0] si,
			input logic sh, input logic [15:0] imm, input bit chk,
			input logic [15:0] e_old, input logic [15:0] e_new, input logic [15:0] e_flg);
		dir_row_t r;
		r.c = '{op, di, dh, wd, simm, si, sh, imm};
		r.chk = chk;
		r.e = '{e_old, e_new, e_flg};
		return r;
	endfunction

	// small register set so dependent items follow each other closely
	function automatic logic [IDX_W-1:0] tight_reg();
		case ($urandom_range(0, 2))
			0: return REG_A;
			1: return REG_B;
			default: return FLAGS_IDX;
		endcase
	endfunction

	function automatic logic [IDX_W-1:0] wide_reg();
		if ($urandom_range(0, 9) == 0)
			return IDX_OOR;
		return IDX_W'($urandom_range(0, NUM_REGS - 1));
	endfunction

	function automatic cmd_t rand_cmd(input bit tight);
		cmd_t c;
		int pick;
		c = $bits(cmd_t)'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 8)
			c.op = OP_NONE;
		else if (pick < 14)
			c.op = 3'($urandom_range(OP_RSVD5, OP_RSVD7));
		else
			c.op = 3'($urandom_range(OP_MOV, OP_CMP));
		c.dest_index = tight ? tight_reg() : wide_reg();
		c.source_index = tight ? tight_reg() : wide_reg();
		// corner immediates now and then: zero, sign boundaries and all-ones
		if ($urandom_range(0, 4) == 0) begin
			case ($urandom_range(0, 5))
				0: c.immediate = 16'h0000;
				1: c.immediate = 16'hFFFF;
				2: c.immediate = 16'h0080;
				3: c.immediate = 16'h8000;
				4: c.immediate = 16'h00FF;
				default: c.immediate = 16'h7FFF;
			endcase
		end
		return c;
	endfunction

	// Offer one item, after a random gap if tx_idle_on; valid stays up until the block takes it,
	// payload frozen meanwhile. Prediction happens at the accepting edge.
	task automatic issue(input cmd_t c, input bit chk, input rsp_t typed);
		int gap;
		rsp_t want;
		gap = tx_idle_on ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (cmd_stall);
		want = exec_cmd(c);
		pending_rsp.push_back(chk ? typed : want);
		n_items++;
	endtask

	// drop valid and wait for the pipe to empty completely
	task automatic drain();
		cmd_valid <= 1'b0;
		do @(posedge clk); while (pending_rsp.size() != 0);
	endtask

	task automatic check_rsp(input rsp_t got);
		rsp_t want;
		n_results++;
		if (pending_rsp.size() == 0) begin
			$error("result with nothing pending: old %h new %h flags %h",
				got.old_value, got.new_value, got.flags_word);
			err_cnt++;
		end else begin
			want = pending_rsp.pop_front();
			if (got.old_value !== want.old_value) begin
				$error("old_value: expected %h, got %h", want.old_value, got.old_value);
				err_cnt++;
			end
			if (got.new_value !== want.new_value) begin
				$error("new_value: expected %h, got %h", want.new_value, got.new_value);
				err_cnt++;
			end
			if (got.flags_word !== want.flags_word) begin
				$error("flags_word: expected %h, got %h", want.flags_word, got.flags_word);
				err_cnt++;
			end
		end
	endtask

	// ---------------------------------------------------------------
	// Result sink: random stall per item while rx_idle_on, occasionally one long hold-off
	// ---------------------------------------------------------------
	initial begin : rsp_sink
		int n;
		forever begin
			n = rx_idle_on ? $urandom_range(0, 4) : 0;
			if (rx_hold_req) begin
				n = HOLD_CYC;
				rx_hold_req = 1'b0;
				n_holds++;
			end
			if (n > 0) begin
				rsp_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			// valid is unknown until the first reset edge; only a clean high counts
			do @(posedge clk); while (rsp_valid !== 1'b1);
			check_rsp(rsp);
		end
	end

	// Watchdog: counts edges at which no item moves on either channel
	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
			idle_cyc <= 0;
		else
			idle_cyc <= idle_cyc + 1;
		if (idle_cyc >= WDOG_LIMIT) begin
			$display("timeout: nothing moved for %0d cycles, %0d results pending",
				idle_cyc, pending_rsp.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------
	initial begin : stimulus
		dir_row_t tab [$];
		int k, i;
		foreach (gpr_shadow[j])
			gpr_shadow[j] = 16'h0000;
		foreach (op_cnt[j])
			op_cnt[j] = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Typed rows follow one another from the all-zero file;
		// flags 0044 is Z with P, 0084 is S with P, 0104 is P over a raw write of 0144.
		//                op        dest       dh    w     imm   src        sh    immediate
		tab.push_back(row(OP_NONE, REG_A,     1'b0, 1'b1, 1'b1, REG_A,     1'b0, 16'h0000,
			1, 16'h0000, 16'h0000, 16'h0000));  // nothing on an empty file
		tab.push_back(row(OP_MOV,  REG_A,     1'b0, 1'b1, 1'b1, REG_A,     1'b0, 16'hFFFF,
			1, 16'h0000, 16'hFFFF, 16'h0000));  // mov leaves flags alone
		tab.push_back(row(OP_ADD,  REG_A,     1'b0, 1'b1, 1'b1, REG_A,     1'b0, 16'h0001,
			1, 16'hFFFF, 16'h0000, 16'h0044));  // word wrap to zero
		tab.push_back(row(OP_MOV,  REG_B,     1'b1, 1'b0, 1'b1, REG_A,     1'b0, 16'h1280,
			1, 16'h0000, 16'h0080, 16'h0044));  // high byte, immediate low byte only
		tab.push_back(row(OP_SUB,  REG_B,     1'b0, 1'b0, 1'b1, REG_A,     1'b0, 16'h0001,
			1, 16'h0000, 16'h00FF, 16'h0084));  // byte borrow, sign from bit 7
		tab.push_back(row(OP_CMP,  REG_B,     1'b0, 1'b1, 1'b0, REG_B,     1'b0, 16'h0000,
			1, 16'h80FF, 16'h80FF, 16'h0044));  // cmp against itself, no writeback
		tab.push_back(row(OP_MOV,  REG_NIL,   1'b0, 1'b1, 1'b0, REG_B,     1'b0, 16'h0000,
			1, 16'h0000, 16'h80FF, 16'h0044));  // index zero holds data
		tab.push_back(row(OP_ADD,  FLAGS_IDX, 1'b0, 1'b1, 1'b1, REG_A,     1'b0, 16'h0100,
			1, 16'h0044, 16'h0144, 16'h0104));  // flags as destination
		tab.push_back(row(OP_MOV,  IDX_OOR,   1'b0, 1'b1, 1'b1, REG_A,     1'b0, 16'h1234,
			1, 16'h0000, 16'h1234, 16'h0104));  // write past the file dropped
		// predicted from here on
		tab.push_back(row(OP_ADD,  REG_C,     1'b0, 1'b1, 1'b0, IDX_OOR,   1'b0, 16'hFFFF,
			0, '0, '0, '0));
		tab.push_back(row(OP_MOV,  REG_C,     1'b0, 1'b0, 1'b0, REG_B,     1'b1, 16'h0000,
			0, '0, '0, '0));
		tab.push_back(row(OP_MOV,  REG_C,     1'b1, 1'b1, 1'b0, REG_B,     1'b1, 16'h0000,
			0, '0, '0, '0));  // half selects ignored on word access
		tab.push_back(row(OP_RSVD5, REG_B,    1'b1, 1'b0, 1'b1, REG_A,     1'b0, 16'hFFFF,
			0, '0, '0, '0));
		tab.push_back(row(OP_RSVD6, FLAGS_IDX, 1'b0, 1'b1, 1'b0, REG_A,    1'b1, 16'h8000,
			0, '0, '0, '0));
		tab.push_back(row(OP_RSVD7, REG_A,    1'b0, 1'b1, 1'b1, REG_B,     1'b0, 16'h7FFF,
			0, '0, '0, '0));
		tab.push_back(row(OP_ADD,  REG_A,     1'b0, 1'b1, 1'b1, REG_A,     1'b0, 16'h8000,
			0, '0, '0, '0));
		tab.push_back(row(OP_ADD,  REG_A,     1'b0, 1'b1, 1'b1, REG_A,     1'b0, 16'h8000,
			0, '0, '0, '0));
		tab.push_back(row(OP_SUB,  REG_NIL,   1'b0, 1'b1, 1'b1, REG_A,     1'b0, 16'hFFFF,
			0, '0, '0, '0));
		tab.push_back(row(OP_CMP,  REG_B,     1'b1, 1'b0, 1'b1, REG_A,     1'b0, 16'h0080,
			0, '0, '0, '0));
		tab.push_back(row(OP_SUB,  FLAGS_IDX, 1'b1, 1'b0, 1'b1, REG_A,     1'b0, 16'h00FF,
			0, '0, '0, '0));
		tab.push_back(row(OP_CMP,  IDX_OOR,   1'b0, 1'b1, 1'b1, REG_A,     1'b0, 16'h0000,
			0, '0, '0, '0));
		tab.push_back(row(OP_MOV,  IDX_OOR,   1'b1, 1'b0, 1'b0, REG_B,     1'b0, 16'h0000,
			0, '0, '0, '0));
		tab.push_back(row(OP_ADD,  REG_A,     1'b0, 1'b0, 1'b0, FLAGS_IDX, 1'b0, 16'h0000,
			0, '0, '0, '0));
		tab.push_back(row(OP_MOV,  FLAGS_IDX, 1'b0, 1'b1, 1'b1, REG_A,     1'b0, 16'hFFFF,
			0, '0, '0, '0));  // mov straight into the flags word

		foreach (tab[j])
			issue(tab[j].c, tab[j].chk, tab[j].e);

		// sender pause: let every pending result out before the random part
		drain();
		n_drains++;

		// Random part in chunks; idling mode rotates so gaps land on every pipe phase:
		// both sides idle, sender flat out, nobody idles (both with tight registers), both idle again.
		for (k = 0; k < N_CHUNKS; k++) begin
			tx_idle_on = (k % 4 == 0) || (k % 4 == 3);
			rx_idle_on = (k % 4 != 2);
			// long hold-off while the sender keeps pushing: pipe fills, input stalls
			if (k % 4 == 1)
				rx_hold_req = 1'b1;
			if (k == N_CHUNKS / 2) begin
				drain();
				n_drains++;
			end
			for (i = 0; i < CHUNK_ITEMS; i++)
				issue(rand_cmd(k % 4 == 1 || k % 4 == 2), 1'b0, '0);
		end

		// wind down: empty the pipe, then a short tail for anything unexpected
		tx_idle_on = 1'b0;
		drain();
		repeat (TAIL_CYC) @(posedge clk);
		if (pending_rsp.size() != 0) begin
			$error("%0d results never arrived", pending_rsp.size());
			err_cnt++;
		end

		$display("Ran %0d items, %0d results checked: none %0d mov %0d add %0d sub %0d cmp %0d",
			n_items, n_results, op_cnt[OP_NONE], op_cnt[OP_MOV], op_cnt[OP_ADD],
			op_cnt[OP_SUB], op_cnt[OP_CMP]);
		$display("Reserved ops %0d, long hold-offs %0d, full drains %0d, mismatches %0d",
			op_cnt[OP_RSVD5] + op_cnt[OP_RSVD6] + op_cnt[OP_RSVD7], n_holds, n_drains,
			err_cnt);
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
